/* rtl/nfpb_pkg.sv */
package nfpb_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned DistW  = 64;
    localparam int unsigned IdxW   = 10;
    localparam int unsigned WtW    = 31;
    localparam int unsigned Slots  = 4;

    localparam logic [DistW-1:0] MaxDist  = {DistW{1'b1}};
    localparam logic [DistW-1:0] FarLimit = 64'd1073741824;
    localparam logic [31:0]      OneQ30   = 32'd1073741824;
    localparam logic [16:0]      Log2eQ16 = 17'd94548;

    localparam logic [0:0] KindLoad  = 1'b0;
    localparam logic [0:0] KindQuery = 1'b1;

    typedef logic [DistW-1:0] t_dist;

    typedef struct packed {
        logic        kind;
        logic        restart;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [IdxW-1:0] index_0;
        logic [IdxW-1:0] index_1;
        logic [IdxW-1:0] index_2;
        logic [IdxW-1:0] index_3;
        logic [7:0]      weight_0;
        logic [7:0]      weight_1;
        logic [7:0]      weight_2;
        logic [7:0]      weight_3;
        logic            too_far;
        logic            status;
    } t_out;

    typedef struct packed {
        logic  valid;
        logic  clear;
        logic  moved;
        t_dist dsq;
        logic [IdxW-1:0] idx;
    } t_cand;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_WDIV, S_WMUL, S_WFRAC, S_WSHIFT,
        S_NDIV, S_OUT
    } t_state;

    function automatic logic [31:0] frac_factor(input logic [2:0] i);
        logic [31:0] c;
        case (i)
            3'd0: c = 32'd759250125;
            3'd1: c = 32'd902905651;
            3'd2: c = 32'd984625594;
            3'd3: c = 32'd1028218693;
            3'd4: c = 32'd1050733751;
            3'd5: c = 32'd1062175490;
            3'd6: c = 32'd1067942999;
            default: c = 32'd1070838486;
        endcase
        return c;
    endfunction

endpackage

/* rtl/nfpb_if.sv */
interface nfpb_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/nfpb_ram.sv */
module nfpb_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/nfpb_dist.sv */
module nfpb_dist (
    input  logic                 i_clk,
    input  logic [31:0]          i_qx,
    input  logic [31:0]          i_qy,
    input  logic [31:0]          i_qz,
    input  logic [31:0]          i_cx,
    input  logic [31:0]          i_cy,
    input  logic [31:0]          i_cz,
    output nfpb_pkg::t_dist      o_dist
);
    import nfpb_pkg::*;

    logic [32:0] n_ax, n_ay, n_az, r_ax, r_ay, r_az;
    logic [65:0] r_sx, r_sy, r_sz;
    logic [66:0] n_sum;
    t_dist r_dist;

    function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    always_comb begin
        n_ax = absdiff(i_qx, i_cx);
        n_ay = absdiff(i_qy, i_cy);
        n_az = absdiff(i_qz, i_cz);
        n_sum = 67'(r_sx) + 67'(r_sy) + 67'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_az <= n_az;
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;
        r_sz <= r_az * r_az;
        r_dist <= (n_sum[66:64] != 3'd0) ? MaxDist : n_sum[63:0];
    end

    assign o_dist = r_dist;
endmodule

/* rtl/nfpb_cell.sv */
module nfpb_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nfpb_pkg::t_cand     i_cand,
    output nfpb_pkg::t_cand     o_cand,
    output nfpb_pkg::t_dist     o_dist,
    output logic [nfpb_pkg::IdxW-1:0] o_idx
);
    import nfpb_pkg::*;

    t_dist           r_dist;
    logic [IdxW-1:0] r_idx;
    t_cand           r_out, n_out;
    t_dist           n_dist;
    logic [IdxW-1:0] n_idx;

    // An entry pushed out of an earlier cell precedes this cell's entry on a tie.
    always_comb begin
        n_dist = r_dist;
        n_idx  = r_idx;
        n_out  = i_cand;
        if (i_cand.clear) begin
            n_dist = MaxDist;
            n_idx  = '0;
        end else if (i_cand.valid && (i_cand.dsq < r_dist ||
                     (i_cand.moved && i_cand.dsq == r_dist))) begin
            n_dist = i_cand.dsq;
            n_idx  = i_cand.idx;
            n_out.dsq   = r_dist;
            n_out.idx   = r_idx;
            n_out.moved = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_out.clear <= 1'b0;
        end else begin
            r_out.valid <= n_out.valid;
            r_out.clear <= n_out.clear;
        end
        r_out.moved <= n_out.moved;
        r_out.dsq   <= n_out.dsq;
        r_out.idx   <= n_out.idx;
        r_dist <= n_dist;
        r_idx  <= n_idx;
    end

    assign o_cand = r_out;
    assign o_dist = r_dist;
    assign o_idx  = r_idx;
endmodule

/* rtl/nearest_four_point_binding.sv */
// Loads are accepted while the block is idle and no result is waiting. A query
// over N stored points scans them all, flushes them through the four-cell
// sorting chain, computes a weight per slot (bit-serial divide, shared 32x32
// multiply), normalizes each weight and outputs; a hard bind skips normalization.
// One item is in work at a time. Synchronous active-low reset empties the
// store and sets falloff_sq to 1.0; the point memory is not cleared.
module nearest_four_point_binding #(
    parameter int unsigned CAGE_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    nfpb_if.sink        i_in,
    nfpb_if.source      o_out
);
    import nfpb_pkg::*;

    localparam int unsigned AW = $clog2(CAGE_POINTS);
    localparam int unsigned CW = $clog2(CAGE_POINTS + 1);

    t_state          r_state, n_state;
    logic [31:0]     r_falloff;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_scan, n_scan;
    logic [3:0]      r_pipe_v;
    logic [CW-1:0]   r_pidx [4];
    logic [3:0]      r_drain, n_drain;
    logic [31:0]     r_qx, r_qy, r_qz;
    t_out            r_res, n_res;
    logic            r_ovalid, n_ovalid;
    logic            r_clear, n_clear;

    logic [1:0]      r_slot, n_slot;
    logic [63:0]     r_num, n_num;
    logic [63:0]     r_quo, n_quo;
    logic [63:0]     r_rem, n_rem;
    logic [6:0]      r_bit, n_bit;
    logic [31:0]     r_w, n_w;
    logic [WtW-1:0]  r_wt [Slots];
    logic [WtW-1:0]  n_wt [Slots];
    logic [33:0]     r_sum, n_sum;
    logic [15:0]     r_t, n_t;
    logic [63:0]     r_prod;
    logic [31:0]     n_ma, n_mb;
    logic            r_hard, n_hard;

    logic            in_fire, out_fire;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     rd_x, rd_y, rd_z;
    t_dist           dist_q;
    t_cand           chain_in;
    t_cand           chain [Slots+1];
    t_dist           cell_d [Slots];
    logic [IdxW-1:0] cell_i [Slots];
    logic [64:0]     trial;
    logic [63:0]     div_den;
    logic [63:0]     sub;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_ovalid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    assign ram_we = in_fire && i_in.data.kind == KindLoad &&
                    (i_in.data.restart || r_count < CW'(CAGE_POINTS));
    assign ram_waddr = i_in.data.restart ? '0 : r_count[AW-1:0];

    nfpb_ram #(.Width(32), .Depth(CAGE_POINTS)) u_ram_x (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_in.data.pos_x),
        .i_raddr(r_scan[AW-1:0]), .o_rdata(rd_x));
    nfpb_ram #(.Width(32), .Depth(CAGE_POINTS)) u_ram_y (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_in.data.pos_y),
        .i_raddr(r_scan[AW-1:0]), .o_rdata(rd_y));
    nfpb_ram #(.Width(32), .Depth(CAGE_POINTS)) u_ram_z (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_in.data.pos_z),
        .i_raddr(r_scan[AW-1:0]), .o_rdata(rd_z));

    nfpb_dist u_dist (
        .i_clk, .i_qx(r_qx), .i_qy(r_qy), .i_qz(r_qz),
        .i_cx(rd_x), .i_cy(rd_y), .i_cz(rd_z), .o_dist(dist_q));

    always_comb begin
        chain_in.valid = r_pipe_v[3];
        chain_in.clear = r_clear;
        chain_in.moved = 1'b0;
        chain_in.dsq   = dist_q;
        chain_in.idx   = IdxW'(r_pidx[3]);
        chain[0] = chain_in;
    end

    for (genvar g = 0; g < Slots; g++) begin : g_cell
        nfpb_cell u_cell (
            .i_clk, .i_rst_n, .i_cand(chain[g]), .o_cand(chain[g+1]),
            .o_dist(cell_d[g]), .o_idx(cell_i[g]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_v <= '0;
        end else begin
            r_pipe_v <= {r_pipe_v[2:0], r_state == S_SCAN && r_scan < r_count};
        end
        r_pidx[0] <= r_scan;
        for (int i = 1; i < 4; i++) begin
            r_pidx[i] <= r_pidx[i-1];
        end
        r_prod <= n_ma * n_mb;
    end

    always_comb begin
        div_den = (r_state == S_WDIV) ? {32'd0, r_falloff} : {30'd0, r_sum};
        trial   = {r_rem, r_num[63]};
        sub     = trial[63:0] - div_den;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_scan  = r_scan;
        n_drain = r_drain;
        n_res   = r_res;
        n_ovalid = r_ovalid;
        n_clear = 1'b0;
        n_slot  = r_slot;
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_w     = r_w;
        n_wt    = r_wt;
        n_sum   = r_sum;
        n_t     = r_t;
        n_hard  = r_hard;
        n_ma    = r_w;
        n_mb    = {16'd0, r_t};
        if (out_fire) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                n_scan = '0;
                if (in_fire) begin
                    if (i_in.data.kind == KindLoad) begin
                        if (i_in.data.restart) begin
                            n_count = CW'(1);
                        end else if (r_count < CW'(CAGE_POINTS)) begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_res = '0;
                        n_res.status = 1'b1;
                        n_ovalid = 1'b1;
                    end else begin
                        n_clear = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_scan = r_scan + CW'(1);
                if (r_scan == r_count) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 4'd1;
                if (r_drain == 4'd8) begin
                    n_slot = '0;
                    n_sum  = '0;
                    n_hard = (r_falloff == '0) || r_falloff[31];
                    n_num  = cell_d[0];
                    n_rem  = '0;
                    n_bit  = '0;
                    n_state = n_hard ? S_OUT : S_WDIV;
                end
            end
            S_WDIV: begin
                n_num = {r_num[62:0], 1'b0};
                if (trial[64] || sub[63:0] <= trial[63:0] && trial >= {1'b0, div_den}) begin
                    n_rem = sub;
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = trial[63:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_bit = r_bit + 7'd1;
                if (r_bit == 7'd63) begin
                    n_state = S_WMUL;
                    n_bit = '0;
                end
            end
            S_WMUL: begin
                n_ma = r_quo[31:0];
                n_mb = {15'd0, Log2eQ16};
                n_bit = r_bit + 7'd1;
                if (r_bit == 7'd1) begin
                    n_t = 16'(r_prod[63:24]);
                    n_w = OneQ30;
                    n_bit = '0;
                    if (r_quo >= 64'd2097152 || r_prod[63:32] >= 32'd31) begin
                        n_wt[r_slot] = '0;
                        n_state = S_WSHIFT;
                        n_w = '0;
                        n_t = '0;
                    end else begin
                        n_state = S_WFRAC;
                    end
                end
            end
            S_WFRAC: begin
                n_ma = r_w;
                n_mb = frac_factor(r_bit[3:1]);
                n_bit = r_bit + 7'd1;
                if (r_bit[0] && r_t[3'd7 - r_bit[3:1]]) begin
                    n_w = r_prod[61:30];
                end
                if (r_bit == 7'd15) begin
                    n_state = S_WSHIFT;
                end
            end
            S_WSHIFT: begin
                n_wt[r_slot] = WtW'(r_w >> r_t[12:8]);
                n_sum = r_sum + 34'(WtW'(r_w >> r_t[12:8]));
                n_slot = r_slot + 2'd1;
                n_bit = '0;
                n_rem = '0;
                n_num = cell_d[r_slot + 2'd1];
                if (r_slot == 2'd3) begin
                    n_slot = '0;
                    if (n_sum == '0) begin
                        n_hard = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_num = 64'(r_wt[0]) * 64'd255;
                        n_state = S_NDIV;
                    end
                end else begin
                    n_state = S_WDIV;
                end
            end
            S_NDIV: begin
                n_num = {r_num[62:0], 1'b0};
                if (trial[64] || trial >= {1'b0, div_den}) begin
                    n_rem = sub;
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = trial[63:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_bit = r_bit + 7'd1;
                if (r_bit == 7'd63) begin
                    n_bit = '0;
                    n_rem = '0;
                    n_slot = r_slot + 2'd1;
                    n_num = 64'(r_wt[r_slot + 2'd1]) * 64'd255;
                    unique case (r_slot)
                        2'd0: n_res.weight_0 = n_quo[7:0];
                        2'd1: n_res.weight_1 = n_quo[7:0];
                        2'd2: n_res.weight_2 = n_quo[7:0];
                        default: n_res.weight_3 = n_quo[7:0];
                    endcase
                    if (r_slot == 2'd3) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                n_res.index_0 = cell_i[0];
                n_res.index_1 = cell_i[1];
                n_res.index_2 = cell_i[2];
                n_res.index_3 = cell_i[3];
                if (r_hard) begin
                    n_res.weight_0 = 8'd255;
                    n_res.weight_1 = '0;
                    n_res.weight_2 = '0;
                    n_res.weight_3 = '0;
                end
                n_res.too_far = cell_d[0] > FarLimit;
                n_res.status = 1'b0;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_falloff <= 32'd65536;
            r_ovalid  <= 1'b0;
            r_clear   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_clear  <= n_clear;
            if (i_cfg_we) begin
                r_falloff <= i_cfg_wdata;
            end
        end
        r_scan  <= n_scan;
        r_drain <= n_drain;
        r_res   <= n_res;
        r_slot  <= n_slot;
        r_num   <= n_num;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_w     <= n_w;
        r_wt    <= n_wt;
        r_sum   <= n_sum;
        r_t     <= n_t;
        r_hard  <= n_hard;
        if (in_fire) begin
            r_qx <= i_in.data.pos_x;
            r_qy <= i_in.data.pos_y;
            r_qz <= i_in.data.pos_z;
        end
    end
endmodule
